/* src/assert_macros.svh */
// Assertion macros shared by the positional PID step RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication: whenever ante holds, cons holds as well.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication: whenever ante holds, cons holds in the following cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* src/pps_pkg.sv */
// Shared types and constants of the positional PID step block.
package pps_pkg;

   localparam int unsigned Q_FRAC    = 16;
   localparam int unsigned DIV_STEPS = 32;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic signed [31:0] SETPOINT_RESET = 32'sd6553600;
   localparam logic [63:0]        DER_LIMIT      = 64'h0001_0000_0000_0000;

   localparam int unsigned CSR_IDX_W = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SETPOINT = 2'd0,
      CSR_GAIN_P   = 2'd1,
      CSR_GAIN_I   = 2'd2,
      CSR_GAIN_D   = 2'd3
   } pps_csr_idx_type;

   typedef struct packed {
      logic signed [31:0] measured;
      logic [30:0]        step_int;
      logic [30:0]        step_deriv;
   } pps_req_type;

   typedef struct packed {
      logic signed [31:0] drive;
      logic               saturated;
      logic               zero_step;
   } pps_rsp_type;

   typedef struct packed {
      logic capture;
      logic mul_i;
      logic mul_th;
      logic mul_tl;
      logic mul_p;
      logic mul_d;
      logic div_load;
      logic der_load;
      logic out_load;
   } pps_cmd_type;

   typedef struct packed {
      logic zero_step;
      logic div_done;
   } pps_status_type;

endpackage

/* src/positional_pid_step_top.sv */
// Top level of the positional PID step block in Q16.16 fixed point.
// A zero derivative step skips the radix-4 divider. One item is handled at a time:
// the next request is taken in the cycle after the current response is loaded.
// Reset is synchronous and active high: setpoint returns to 100.0, gains, integral
// and last error return to zero, and no response is pending.
module positional_pid_step_top
   import pps_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  pps_req_type          req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output pps_rsp_type          rsp_payload,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_data
);

   // Command and status between the sequencer and the datapath.
   pps_cmd_type    cmd;
   pps_status_type status;

   // Configuration writes are always taken. The registers must only be written
   // while no item is in flight, so no interlock with the sequencer is needed.
   assign csr_ready = 1'b1;

   // The sequencer walks one item through five multiplier passes on a single
   // shared 33x32 multiplier (integral gain, two halves of the integral step
   // product, proportional gain, derivative gain), then the serial divider for a
   // nonzero derivative step, then the final sum. The response sits in an output
   // register, so the sequencer returns to idle as soon as the response beat is
   // loaded and a new request beat can be accepted while the old response waits.
   pps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the configuration registers, the integral and last
   // error state, the intermediate results and the response register. The
   // error is formed and saturated as the request beat is captured.
   pps_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

endmodule

/* src/pps_ctrl.sv */
// Sequencing state machine of the positional PID step block.
`include "assert_macros.svh"

module pps_ctrl
   import pps_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   input  pps_status_type status,
   output pps_cmd_type    cmd
);

   typedef enum logic [9:0] {
      S_IDLE  = 10'b00_0000_0001,
      S_MI    = 10'b00_0000_0010,
      S_MTH   = 10'b00_0000_0100,
      S_MTL   = 10'b00_0000_1000,
      S_MP    = 10'b00_0001_0000,
      S_MD    = 10'b00_0010_0000,
      S_DINIT = 10'b00_0100_0000,
      S_DIV   = 10'b00_1000_0000,
      S_DER   = 10'b01_0000_0000,
      S_OUT   = 10'b10_0000_0000
   } pps_state_type;

   pps_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_MI;
            end
         end
         S_MI: begin
            cmd.mul_i = 1'b1;
            state_in  = S_MTH;
         end
         S_MTH: begin
            cmd.mul_th = 1'b1;
            state_in   = S_MTL;
         end
         S_MTL: begin
            cmd.mul_tl = 1'b1;
            state_in   = S_MP;
         end
         S_MP: begin
            cmd.mul_p = 1'b1;
            state_in  = S_MD;
         end
         S_MD: begin
            cmd.mul_d = 1'b1;
            state_in  = S_DINIT;
         end
         S_DINIT: begin
            cmd.div_load = 1'b1;
            state_in     = status.zero_step ? S_OUT : S_DIV;
         end
         S_DIV: begin
            if (status.div_done) begin
               state_in = S_DER;
            end
         end
         S_DER: begin
            cmd.der_load = 1'b1;
            state_in     = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `ASSERT_IMPLY(a_load_into_free_slot, clock, reset, cmd.out_load, out_free)
   `ASSERT_IMPLY(a_div_only_nonzero_step, clock, reset, state_ff == S_DIV, !status.zero_step)

endmodule

/* src/pps_div.sv */
// Radix-4 restoring divider for the derivative term.
`include "assert_macros.svh"

module pps_div
   import pps_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] numer,
   input  logic [30:0] denom,
   output logic        done,
   output logic [63:0] quot
);

   logic [30:0]          rem_ff, rem_in;
   logic [63:0]          num_ff, num_in;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;

   // Two quotient bits per cycle; the quotient shifts in where the
   // dividend shifts out.
   always_comb begin
      logic [31:0] trial;
      logic        qbit;
      rem_in = rem_ff;
      num_in = num_ff;
      for (int i = 0; i < 2; i++) begin
         trial = {rem_in, num_in[63]};
         qbit  = (trial >= {1'b0, denom});
         if (qbit) begin
            trial = trial - {1'b0, denom};
         end
         rem_in = trial[30:0];
         num_in = {num_in[62:0], qbit};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         num_ff <= numer;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         num_ff <= num_in;
      end
   end

   assign done = done_ff;
   assign quot = num_ff;

   `ASSERT_IMPLY(a_busy_not_done, clock, reset, busy_ff, !done_ff)
   `ASSERT_NEXT(a_start_runs, clock, reset, start, busy_ff && !done_ff)

endmodule

/* src/pps_dp.sv */
// Datapath of the positional PID step: registers, shared multiplier, divider.
module pps_dp
   import pps_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_data,
   input  pps_req_type          req_payload,
   input  pps_cmd_type          cmd,
   output pps_status_type       status,
   output pps_rsp_type          rsp_payload
);

   // Returns {hit, value}: value saturated to the signed 32-bit range.
   function automatic logic [32:0] sat32(input logic signed [65:0] x);
      logic hit;
      hit = (x[65:31] != {35{x[65]}});
      if (!hit) begin
         return {1'b0, x[31:0]};
      end else if (x[65]) begin
         return {1'b1, 32'h8000_0000};
      end else begin
         return {1'b1, 32'h7FFF_FFFF};
      end
   endfunction

   logic signed [31:0] setpoint_ff, gain_p_ff, gain_i_ff, gain_d_ff;
   logic signed [31:0] isum_ff, last_err_ff;

   logic signed [31:0] err_ff;
   logic [30:0]        dt_ff, dl_ff;
   logic signed [32:0] diff_ff;
   logic [15:0]        tl_ff;
   logic signed [64:0] prod_ff;
   logic signed [64:0] acc_ff;
   logic signed [48:0] prop_ff;
   logic signed [31:0] intg_ff;
   logic               sat_ff;
   logic signed [49:0] part_ff;
   logic               neg_ff;
   logic signed [49:0] der_ff;
   pps_rsp_type        result_ff;

   logic [32:0]        err_sat, intg_sat, drive_sat;
   logic signed [32:0] mul_a;
   logic signed [31:0] mul_b;
   logic signed [64:0] mul_prod;
   logic               mul_any;
   logic [63:0]        der_mag;
   logic               div_start, div_done;
   logic [63:0]        div_quot;
   logic [48:0]        quot_lim;
   logic signed [49:0] der_in;
   logic signed [50:0] total;

   assign err_sat = sat32(66'(setpoint_ff) - 66'(req_payload.measured));
   assign intg_sat = sat32(66'(isum_ff) + 66'(acc_ff));
   assign total = 51'(part_ff) + 51'(der_ff);
   assign drive_sat = sat32(66'(total));

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (cmd.mul_i) begin
         mul_a = 33'(gain_i_ff);
         mul_b = err_ff;
      end else if (cmd.mul_th) begin
         mul_a = 33'(signed'(prod_ff[63:32]));
         mul_b = {1'b0, dt_ff};
      end else if (cmd.mul_tl) begin
         mul_a = {17'd0, tl_ff};
         mul_b = {1'b0, dt_ff};
      end else if (cmd.mul_p) begin
         mul_a = 33'(gain_p_ff);
         mul_b = err_ff;
      end else if (cmd.mul_d) begin
         mul_a = diff_ff;
         mul_b = gain_d_ff;
      end
   end

   assign mul_any  = cmd.mul_i | cmd.mul_th | cmd.mul_tl | cmd.mul_p | cmd.mul_d;
   assign mul_prod = 65'(mul_a) * 65'(mul_b);

   assign der_mag   = prod_ff[64] ? 64'(-prod_ff) : prod_ff[63:0];
   assign div_start = cmd.div_load && (dl_ff != '0);

   pps_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (der_mag),
      .denom (dl_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign quot_lim = (div_quot > DER_LIMIT) ? DER_LIMIT[48:0] : div_quot[48:0];
   assign der_in   = neg_ff ? (50'sd0 - signed'({1'b0, quot_lim}))
                            : signed'({1'b0, quot_lim});

   assign status.zero_step = (dl_ff == '0);
   assign status.div_done  = div_done;
   assign rsp_payload      = result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff <= SETPOINT_RESET;
         gain_p_ff   <= '0;
         gain_i_ff   <= '0;
         gain_d_ff   <= '0;
      end else if (csr_write) begin
         case (pps_csr_idx_type'(csr_index))
            CSR_SETPOINT: setpoint_ff <= csr_data;
            CSR_GAIN_P:   gain_p_ff   <= csr_data;
            CSR_GAIN_I:   gain_i_ff   <= csr_data;
            CSR_GAIN_D:   gain_d_ff   <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         isum_ff     <= '0;
         last_err_ff <= '0;
      end else if (cmd.out_load) begin
         isum_ff     <= intg_ff;
         last_err_ff <= err_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         err_ff <= err_sat[31:0];
         dt_ff  <= req_payload.step_int;
         dl_ff  <= req_payload.step_deriv;
      end
      if (mul_any) begin
         prod_ff <= mul_prod;
      end
      if (cmd.mul_i) begin
         diff_ff <= 33'(err_ff) - 33'(last_err_ff);
      end
      if (cmd.mul_th) begin
         tl_ff <= prod_ff[31:16];
      end
      if (cmd.mul_tl) begin
         acc_ff <= prod_ff;
      end
      if (cmd.mul_p) begin
         acc_ff <= acc_ff + (prod_ff >>> Q_FRAC);
      end
      if (cmd.mul_d) begin
         prop_ff <= prod_ff[64:16];
         intg_ff <= intg_sat[31:0];
         sat_ff  <= intg_sat[32];
      end
      if (cmd.div_load) begin
         part_ff <= 50'(prop_ff) + 50'(intg_ff);
         neg_ff  <= prod_ff[64];
         der_ff  <= '0;
      end
      if (cmd.der_load) begin
         der_ff <= der_in;
      end
      if (cmd.out_load) begin
         result_ff.drive     <= drive_sat[31:0];
         result_ff.saturated <= sat_ff | drive_sat[32];
         result_ff.zero_step <= status.zero_step;
      end
   end

endmodule

/* test/positional_pid_step_tb.sv */
// Self-checking testbench for the positional PID step block: directed corners, then random beats.
`timescale 1ns / 1ps

module testbench
   import pps_pkg::*;
;

   // Q16.16 constants used to build stimulus.
   localparam logic [31:0] ONE      = 32'h0001_0000;
   localparam logic [31:0] WORD_MIN = 32'h8000_0000;
   localparam logic [31:0] WORD_MAX = 32'h7FFF_FFFF;
   localparam logic [30:0] STEP_MAX = 31'h7FFF_FFFF;

   // Tracks the controller state and settings, predicts each response beat and
   // checks the beats that come out of the block in order.
   class pid_scoreboard;
      localparam longint SAT_HI = 64'sd2147483647;
      localparam longint SAT_LO = -64'sd2147483648;

      logic signed [31:0] setpoint;
      logic signed [31:0] gain_p;
      logic signed [31:0] gain_i;
      logic signed [31:0] gain_d;
      logic signed [31:0] integral_sum;
      logic signed [31:0] last_error;
      pps_rsp_type        drive_expected_q[$];
      int unsigned        mismatches;
      int unsigned        checked;
      int unsigned        sat_seen;
      int unsigned        zero_seen;

      function new();
         setpoint     = SETPOINT_RESET;
         gain_p       = '0;
         gain_i       = '0;
         gain_d       = '0;
         integral_sum = '0;
         last_error   = '0;
         mismatches   = 0;
         checked      = 0;
         sat_seen     = 0;
         zero_seen    = 0;
      endfunction

      function void write_reg(pps_csr_idx_type idx, logic [31:0] value);
         case (idx)
            CSR_SETPOINT: setpoint = value;
            CSR_GAIN_P:   gain_p   = value;
            CSR_GAIN_I:   gain_i   = value;
            CSR_GAIN_D:   gain_d   = value;
            default: begin
            end
         endcase
      endfunction

      function longint clamp_to(longint x, longint lo, longint hi, inout bit hit);
         if (x > hi) begin
            hit = 1'b1;
            return hi;
         end
         if (x < lo) begin
            hit = 1'b1;
            return lo;
         end
         return x;
      endfunction

      // Works out the response to one accepted request beat and advances the state.
      function void predict_drive(pps_req_type req);
         longint      err, t, th, tl, dt, dl, inc, intg, der, prop, total;
         bit          quiet_hit, sat;
         pps_rsp_type want;
         quiet_hit = 1'b0;
         sat       = 1'b0;
         dt        = longint'(req.step_int);
         dl        = longint'(req.step_deriv);
         // Error overflow saturates without raising the saturated flag.
         err = clamp_to(longint'(setpoint) - longint'($signed(req.measured)),
                        SAT_LO, SAT_HI, quiet_hit);
         // Integral increment, split so that the product with the step stays in 64 bits.
         t    = (longint'(gain_i) * err) >>> Q_FRAC;
         th   = t >>> Q_FRAC;
         tl   = t - (th <<< Q_FRAC);
         inc  = th * dt + ((tl * dt) >>> Q_FRAC);
         intg = clamp_to(longint'(integral_sum) + inc, SAT_LO, SAT_HI, sat);
         if (dl == 0) begin
            der = 0;
         end else begin
            der = (longint'(gain_d) * (err - longint'(last_error))) / dl;
            der = clamp_to(der, -longint'(DER_LIMIT), longint'(DER_LIMIT), quiet_hit);
         end
         prop  = (longint'(gain_p) * err) >>> Q_FRAC;
         total = clamp_to(prop + intg + der, SAT_LO, SAT_HI, sat);
         integral_sum    = intg[31:0];
         last_error      = err[31:0];
         want.drive      = total[31:0];
         want.saturated  = sat;
         want.zero_step  = (dl == 0);
         drive_expected_q.push_back(want);
      endfunction

      function void check_drive(pps_rsp_type got);
         pps_rsp_type want;
         if (drive_expected_q.size() == 0) begin
            $error("response beat with nothing outstanding: drive %0d", $signed(got.drive));
            mismatches++;
            return;
         end
         want = drive_expected_q.pop_front();
         checked++;
         sat_seen  += got.saturated;
         zero_seen += got.zero_step;
         if (got.drive !== want.drive) begin
            $error("drive: expected %0d, got %0d", $signed(want.drive), $signed(got.drive));
            mismatches++;
         end
         if (got.saturated !== want.saturated) begin
            $error("saturated: expected %0b, got %0b", want.saturated, got.saturated);
            mismatches++;
         end
         if (got.zero_step !== want.zero_step) begin
            $error("zero_step: expected %0b, got %0b", want.zero_step, got.zero_step);
            mismatches++;
         end
      endfunction
   endclass

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   logic                 req_stall;
   pps_req_type          req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_stall   = 1'b0;
   pps_rsp_type          rsp_payload;
   logic                 csr_valid   = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index   = '0;
   logic [31:0]          csr_data    = '0;

   // While calm is set neither side inserts idle cycles.
   bit                   calm        = 1'b0;
   int unsigned          beats_sent  = 0;
   int unsigned          settings_loaded = 0;
   logic [31:0]          corner_meas [4] = '{WORD_MIN, 32'h0, WORD_MAX, 32'hFFFF_FFFF};

   pid_scoreboard sb = new();

   positional_pid_step_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always #2 clock = ~clock;

   // The receiver stalls at random, six times in a hundred, independent of what the
   // block is doing, so stalls land both on waiting and on presented beats.
   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < 6);
   end

   // Sampling at the edge sees the values from the cycle before it, so a response
   // beat is taken exactly when the block counts it as delivered.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         sb.check_drive(rsp_payload);
      end
   end

   // Presents one request beat, possibly after a few idle cycles, and holds it
   // until the block takes it. Called at a rising edge; returns at the accepting edge
   // with valid still high, so the caller either presents the next beat or drops valid.
   task automatic send_item(logic [31:0] meas, logic [30:0] s_int, logic [30:0] s_der);
      pps_req_type item;
      item.measured   = meas;
      item.step_int   = s_int;
      item.step_deriv = s_der;
      while (!calm && $urandom_range(99) < 6) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      sb.predict_drive(item);
      beats_sent++;
   endtask

   // Waits for every outstanding response, then writes all four registers in turn.
   // The block is idle by then since each request beat yields exactly one response.
   task automatic load_settings(logic [31:0] sp, logic [31:0] kp, logic [31:0] ki,
                                logic [31:0] kd);
      logic [31:0]     vals [4];
      pps_csr_idx_type idx;
      vals = '{sp, kp, ki, kd};
      req_valid <= 1'b0;
      while (sb.drive_expected_q.size() != 0) @(posedge clock);
      for (int i = 0; i < 4; i++) begin
         idx = pps_csr_idx_type'(i);
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_data  <= vals[i];
         do @(posedge clock); while (!csr_ready);
         sb.write_reg(idx, vals[i]);
      end
      csr_valid <= 1'b0;
      settings_loaded++;
   endtask

   // Register or measurement value: mostly small signed values within the span,
   // sometimes zero, a full-range word or one of the two extremes.
   function automatic logic [31:0] pick_word(logic [31:0] span);
      logic [31:0] v;
      case ($urandom_range(9))
         0: v = $urandom_range(1) ? WORD_MAX : WORD_MIN;
         1: v = $urandom();
         2: v = 32'h0;
         default: begin
            v = $urandom_range(0, span);
            if ($urandom_range(1)) v = -v;
         end
      endcase
      return v;
   endfunction

   // Time step: mostly up to 2.0, with zero, the maximum and full-range values mixed in.
   function automatic logic [30:0] pick_step();
      logic [30:0] s;
      int unsigned r;
      r = $urandom_range(99);
      if (r < 5)       s = '0;
      else if (r < 10) s = STEP_MAX;
      else if (r < 25) s = 31'($urandom());
      else             s = 31'($urandom_range(0, 32'h0002_0000));
      return s;
   endfunction

   // Hard limit on the run; a healthy run finishes in well under a tenth of this.
   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      int          wait_cycles;
      logic [31:0] meas;
      int unsigned r;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Out of reset the gains are zero, so the drive must be zero whatever the error.
      send_item(32'h0, ONE[30:0], ONE[30:0]);

      // Unit gains with a zero setpoint make every term easy to follow.
      load_settings(32'h0, ONE, ONE, ONE);
      send_item(32'hFFFF_0000, ONE[30:0], ONE[30:0]);
      // The most negative measurement overflows the error, which then saturates quietly.
      send_item(WORD_MIN, ONE[30:0], ONE[30:0]);
      send_item(WORD_MAX, ONE[30:0], ONE[30:0]);
      // A zero derivative step skips the derivative and raises zero_step.
      send_item(32'hFFFE_0000, ONE[30:0], 31'd0);
      send_item(32'h0, 31'd0, STEP_MAX);
      // A long integration step drives the integral into its upper limit and keeps it there.
      send_item(WORD_MIN, STEP_MAX, ONE[30:0]);
      send_item(WORD_MIN, STEP_MAX, 31'd1);
      // Then the error flips sign, swinging the integral and the drive to the other limit.
      send_item(WORD_MAX, STEP_MAX, STEP_MAX);

      // Extreme setpoint and gains in both directions against the measurement corners.
      for (int k = 0; k < 2; k++) begin
         load_settings(k ? WORD_MIN : WORD_MAX, k ? WORD_MIN : WORD_MAX,
                       k ? WORD_MAX : WORD_MIN, k ? WORD_MAX : WORD_MIN);
         for (int j = 0; j < 4; j++) begin
            send_item(corner_meas[j], j[0] ? 31'd1 : STEP_MAX, j[1] ? STEP_MAX : 31'd0);
         end
      end

      // Random part: each phase loads fresh settings and then runs a stream of
      // measurements. Most sit near the setpoint so the integral builds up over many
      // beats instead of sitting at a limit; the rest are full-range or corner values.
      for (int phase = 0; phase < 8; phase++) begin
         load_settings(pick_word(32'h03E8_0000), pick_word(32'h0004_0000),
                       pick_word(32'h0001_0000), pick_word(32'h0004_0000));
         calm <= (phase == 3);
         for (int n = 0; n < 116; n++) begin
            r = $urandom_range(99);
            if (r < 70)      meas = sb.setpoint + $urandom_range(0, 32'h0064_0000)
                                    - 32'h0032_0000;
            else if (r < 85) meas = $urandom();
            else             meas = corner_meas[$urandom_range(3)];
            send_item(meas, pick_step(), pick_step());
         end
      end

      // Drop valid at the edge that took the last beat, then let the pipeline drain.
      req_valid <= 1'b0;
      calm      <= 1'b0;
      wait_cycles = 0;
      while (sb.drive_expected_q.size() != 0 && wait_cycles < 5000) begin
         @(posedge clock);
         wait_cycles++;
      end
      if (sb.drive_expected_q.size() != 0) begin
         $error("%0d response beats never arrived", sb.drive_expected_q.size());
         sb.mismatches++;
      end
      // A little longer than one item's latency, so a stray extra response gets caught.
      repeat (48) @(posedge clock);

      $display("Sent %0d request beats under %0d register settings; %0d responses checked.",
               beats_sent, settings_loaded, sb.checked);
      $display("Responses seen with saturation: %0d, with the derivative skipped: %0d.",
               sb.sat_seen, sb.zero_seen);
      if (sb.mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+src
src/pps_pkg.sv
src/pps_ctrl.sv
src/pps_div.sv
src/pps_dp.sv
src/positional_pid_step_top.sv
test/positional_pid_step_tb.sv
